// File: hw/rtl/pipr_pkg.sv
`timescale 1ns / 1ps

package pipr_pkg;

    typedef struct packed {
        logic signed [30:0] x;
        logic signed [30:0] y;
    } pt_t;

    typedef enum logic [1:0] {
        SGN_ZERO,
        SGN_POS,
        SGN_NEG
    } sgn_t;

    typedef enum logic [1:0] {
        AR_IDLE,
        AR_MUL2,
        AR_CMP
    } ar_st_t;

    typedef struct packed {
        logic done;
        sgn_t sign;
    } area_res_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_E_FIRST,
        ST_E_A0,
        ST_E_RDB,
        ST_E_LDB,
        ST_E_GO,
        ST_E_WAIT,
        ST_R_INIT,
        ST_R_RD,
        ST_R_LD,
        ST_R_GO,
        ST_R_WAIT,
        ST_PUT
    } st_t;

    typedef enum logic [1:0] {
        OP_PAB,
        OP_RAB,
        OP_APR,
        OP_BPR
    } opsel_t;

    localparam logic signed [30:0] REF_X       = 31'sd1000000001;
    localparam logic signed [30:0] REF_Y_START = 31'sd99999999;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic [1:0] POS_OUTSIDE  = 2'd0;
    localparam logic [1:0] POS_INSIDE   = 2'd1;
    localparam logic [1:0] POS_BOUNDARY = 2'd2;

    localparam logic [8:0] MIN_VERTICES = 9'd3;

    function automatic logic between(logic signed [30:0] q, logic signed [30:0] e1,
                                     logic signed [30:0] e2);
        return ((e1 <= q) && (q <= e2)) || ((e2 <= q) && (q <= e1));
    endfunction

    // q within the bounding box of segment e1-e2
    function automatic logic in_box(pt_t q, pt_t e1, pt_t e2);
        return between(q.x, e1.x, e2.x) && between(q.y, e1.y, e2.y);
    endfunction

endpackage

// File: hw/rtl/pipr_area.sv
`timescale 1ns / 1ps

module pipr_area
    import pipr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  pt_t       o_pt,
    input  pt_t       a_pt,
    input  pt_t       b_pt,
    output area_res_t res
);

    ar_st_t state_reg, state_next;
    logic signed [63:0] p1_reg, p2_reg;
    logic signed [31:0] m_l, m_r;
    logic signed [63:0] prod;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= AR_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            AR_IDLE:
            begin
                if (start)
                begin
                    state_next = AR_MUL2;
                end
            end
            AR_MUL2: state_next = AR_CMP;
            AR_CMP:  state_next = AR_IDLE;
            default: state_next = AR_IDLE;
        endcase
    end

    // first product (o.x-a.x)*(o.y-b.y), then (o.x-b.x)*(o.y-a.y)
    always_comb
    begin
        if (state_reg == AR_MUL2)
        begin
            m_l = {o_pt.x[30], o_pt.x} - {b_pt.x[30], b_pt.x};
            m_r = {o_pt.y[30], o_pt.y} - {a_pt.y[30], a_pt.y};
        end
        else
        begin
            m_l = {o_pt.x[30], o_pt.x} - {a_pt.x[30], a_pt.x};
            m_r = {o_pt.y[30], o_pt.y} - {b_pt.y[30], b_pt.y};
        end
        prod = m_l * m_r;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == AR_IDLE && start)
        begin
            p1_reg <= prod;
        end
        if (state_reg == AR_MUL2)
        begin
            p2_reg <= prod;
        end
    end

    always_comb
    begin
        res.done = (state_reg == AR_CMP);
        if (p1_reg > p2_reg)
        begin
            res.sign = SGN_POS;
        end
        else if (p1_reg < p2_reg)
        begin
            res.sign = SGN_NEG;
        end
        else
        begin
            res.sign = SGN_ZERO;
        end
    end

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> state_reg == AR_IDLE) else $error("area start while busy");
    a_start_run: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> state_reg == AR_MUL2) else $error("area did not launch");
    a_mul_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == AR_MUL2 |=> res.done) else $error("area compare missing");

endmodule

// File: hw/rtl/point_in_polygon_ray_cast_unit.sv
`timescale 1ns / 1ps
// Channel   Signals                                             Direction
// in        in_valid/in_ready, req_type vertex_index coord_x/y  into block
// out       out_valid/out_ready, position                       out of block
// cfg       cfg_wr_en, cfg_wr_data (vertex_count)               into block
//
// A query walks the edges for the boundary test, then a bounded series of
// reference tries that each step through the vertices, then the edges for the
// crossing test; the one shared 32x32 multiplier (two products per area sign)
// and the single vertex read port serialise all of this work.
// Reset clears control state and sets vertex_count to 3; vertex memory is not
// cleared. in_ready is high only while idle; a result waits in the output
// register and a finished query holds until that register is free.

module point_in_polygon_ray_cast_unit
    import pipr_pkg::*;
#(
    parameter int MAX_VERTICES = 256
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               req_type,
    input  logic [7:0]         vertex_index,
    input  logic signed [30:0] coord_x,
    input  logic signed [30:0] coord_y,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         position,
    input  logic               cfg_wr_en,
    input  logic [8:0]         cfg_wr_data
);

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);

    pt_t mem [MAX_VERTICES];
    pt_t rd_pt_reg;
    logic [AW-1:0] rd_addr;
    logic          ld_we;

    st_t state_reg, state_next;
    logic [8:0]    vc_reg;
    pt_t           p_reg, a_reg, a_next, b_reg, b_next, v0_reg, v0_next;
    logic signed [30:0] ry_reg, ry_next;
    logic [AW-1:0] i_reg, i_next;
    logic [CW-1:0] t_reg, t_next, n_reg, n_next;
    logic          cross_reg, cross_next;
    logic [1:0]    k_reg, k_next;
    sgn_t          s_reg [3];
    sgn_t          s_next [3];
    logic          hits_reg, hits_next;
    logic [1:0]    res_reg, res_next;
    logic          out_valid_reg, out_valid_next;
    logic [1:0]    pos_reg, pos_next;

    pt_t       ref_pt, op_o, op_a, op_b;
    opsel_t    opsel;
    logic      area_start;
    area_res_t area;
    logic      last_edge, in_acc;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign position  = pos_reg;
    assign in_acc    = in_valid && in_ready;
    assign ld_we     = in_acc && (req_type == REQ_LOAD) &&
                       (32'(vertex_index) < MAX_VERTICES);
    assign ref_pt    = '{x: REF_X, y: ry_reg};
    assign last_edge = (32'(i_reg) + 1 == 32'(n_reg));

    always_ff @(posedge clk)
    begin
        if (ld_we)
        begin
            mem[AW'(vertex_index)] <= '{x: coord_x, y: coord_y};
        end
        rd_pt_reg <= mem[rd_addr];
    end

    always_comb
    begin
        case (state_reg)
            ST_E_RDB: rd_addr = i_reg + AW'(1);
            ST_R_RD:  rd_addr = i_reg;
            default:  rd_addr = '0;
        endcase
    end

    always_comb
    begin
        if (state_reg == ST_R_GO || state_reg == ST_R_WAIT)
        begin
            opsel = OP_APR;
        end
        else if (!cross_reg)
        begin
            opsel = OP_PAB;
        end
        else
        begin
            opsel = opsel_t'(k_reg);
        end
        case (opsel)
            OP_PAB:
            begin
                op_o = p_reg;  op_a = a_reg; op_b = b_reg;
            end
            OP_RAB:
            begin
                op_o = ref_pt; op_a = a_reg; op_b = b_reg;
            end
            OP_APR:
            begin
                op_o = a_reg;  op_a = p_reg; op_b = ref_pt;
            end
            OP_BPR:
            begin
                op_o = b_reg;  op_a = p_reg; op_b = ref_pt;
            end
            default:
            begin
                op_o = p_reg;  op_a = a_reg; op_b = b_reg;
            end
        endcase
    end

    pipr_area u_area (
        .clk   (clk),
        .rst_n (rst_n),
        .start (area_start),
        .o_pt  (op_o),
        .a_pt  (op_a),
        .b_pt  (op_b),
        .res   (area)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            vc_reg        <= MIN_VERTICES;
            out_valid_reg <= 1'b0;
            cross_reg     <= 1'b0;
            k_reg         <= '0;
            hits_reg      <= 1'b0;
            i_reg         <= '0;
            t_reg         <= '0;
            n_reg         <= CW'(3);
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cross_reg     <= cross_next;
            k_reg         <= k_next;
            hits_reg      <= hits_next;
            i_reg         <= i_next;
            t_reg         <= t_next;
            n_reg         <= n_next;
            if (cfg_wr_en)
            begin
                vc_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            p_reg <= '{x: coord_x, y: coord_y};
        end
        a_reg   <= a_next;
        b_reg   <= b_next;
        v0_reg  <= v0_next;
        ry_reg  <= ry_next;
        s_reg   <= s_next;
        res_reg <= res_next;
        pos_reg <= pos_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        v0_next        = v0_reg;
        ry_next        = ry_reg;
        i_next         = i_reg;
        t_next         = t_reg;
        n_next         = n_reg;
        cross_next     = cross_reg;
        k_next         = k_reg;
        s_next         = s_reg;
        hits_next      = hits_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        pos_next       = pos_reg;
        area_start     = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && req_type == REQ_QUERY)
                begin
                    if (vc_reg < MIN_VERTICES)
                    begin
                        n_next = CW'(3);
                    end
                    else if (32'(vc_reg) > MAX_VERTICES)
                    begin
                        n_next = CW'(MAX_VERTICES);
                    end
                    else
                    begin
                        n_next = CW'(vc_reg);
                    end
                    i_next     = '0;
                    cross_next = 1'b0;
                    state_next = ST_E_FIRST;
                end
            end
            ST_E_FIRST: state_next = ST_E_A0;
            ST_E_A0:
            begin
                a_next     = rd_pt_reg;
                v0_next    = rd_pt_reg;
                i_next     = '0;
                state_next = ST_E_RDB;
            end
            ST_E_RDB: state_next = ST_E_LDB;
            ST_E_LDB:
            begin
                // closing edge wraps to vertex zero
                b_next     = last_edge ? v0_reg : rd_pt_reg;
                k_next     = '0;
                state_next = ST_E_GO;
            end
            ST_E_GO:
            begin
                area_start = 1'b1;
                state_next = ST_E_WAIT;
            end
            ST_E_WAIT:
            begin
                if (area.done)
                begin
                    if (!cross_reg && area.sign == SGN_ZERO &&
                        in_box(p_reg, a_reg, b_reg))
                    begin
                        res_next   = POS_BOUNDARY;
                        state_next = ST_PUT;
                    end
                    else if (cross_reg && k_reg != 2'd3)
                    begin
                        s_next[k_reg] = area.sign;
                        k_next        = k_reg + 2'd1;
                        state_next    = ST_E_GO;
                    end
                    else
                    begin
                        if (cross_reg && s_reg[0] != s_reg[1] && s_reg[2] != area.sign)
                        begin
                            hits_next = ~hits_reg;
                        end
                        if (last_edge)
                        begin
                            if (cross_reg)
                            begin
                                res_next   = hits_next ? POS_INSIDE : POS_OUTSIDE;
                                state_next = ST_PUT;
                            end
                            else
                            begin
                                state_next = ST_R_INIT;
                            end
                        end
                        else
                        begin
                            i_next     = i_reg + AW'(1);
                            a_next     = b_reg;
                            state_next = ST_E_RDB;
                        end
                    end
                end
            end
            ST_R_INIT:
            begin
                ry_next    = REF_Y_START + 31'sd1;
                t_next     = '0;
                i_next     = '0;
                state_next = ST_R_RD;
            end
            ST_R_RD: state_next = ST_R_LD;
            ST_R_LD:
            begin
                a_next     = rd_pt_reg;
                state_next = ST_R_GO;
            end
            ST_R_GO:
            begin
                area_start = 1'b1;
                state_next = ST_R_WAIT;
            end
            ST_R_WAIT:
            begin
                if (area.done)
                begin
                    if (area.sign == SGN_ZERO && in_box(a_reg, p_reg, ref_pt))
                    begin
                        // blocked: move reference up unless tries are spent
                        if (32'(t_reg) == MAX_VERTICES)
                        begin
                            cross_next = 1'b1;
                            hits_next  = 1'b0;
                            state_next = ST_E_FIRST;
                        end
                        else
                        begin
                            t_next     = t_reg + CW'(1);
                            ry_next    = ry_reg + 31'sd1;
                            i_next     = '0;
                            state_next = ST_R_RD;
                        end
                    end
                    else if (last_edge)
                    begin
                        cross_next = 1'b1;
                        hits_next  = 1'b0;
                        state_next = ST_E_FIRST;
                    end
                    else
                    begin
                        i_next     = i_reg + AW'(1);
                        state_next = ST_R_RD;
                    end
                end
            end
            ST_PUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    pos_next       = res_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    a_query_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && req_type == REQ_QUERY |=> state_reg == ST_E_FIRST)
        else $error("query not started");
    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> 32'(i_reg) < 32'(n_reg))
        else $error("vertex index beyond count");
    a_area_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        area.done |-> (state_reg == ST_E_WAIT || state_reg == ST_R_WAIT))
        else $error("area result unused");
    a_put_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PUT && state_next == ST_IDLE |=> out_valid_reg)
        else $error("result lost");

endmodule
